// ===== hdl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("port rule violated");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("port rule violated");

`endif

// ===== hdl/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// Widths, types and helper functions of the stroke contour unit.
// ----------------------------------------------------------------------------
package psc_pkg;

	// coordinate format
	localparam int CW = 24;
	localparam int FB = 8;
	localparam int RW = 20;

	// width of the shared bit-serial unit
	localparam int W = 3 * CW + 8;
	localparam int CNT_W = $clog2(W + 1);
	localparam int SQRT_TOP = (W - 2) - (W % 2);

	localparam int EPS_FIX = ((1 << FB) + 50) / 100;

	typedef logic [W-1:0] uw_t;
	typedef logic signed [W:0] sw_t;
	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [CW:0] dw_t;
	typedef logic [CW:0] lw_t;
	typedef logic [RW-1:0] hw_t;

	localparam hw_t HW_RESET = RW'(256);
	localparam uw_t SQ_MIN = W'(64'd1 << (2 * FB));
	localparam sw_t COORD_MAX = (W + 1)'((64'sd1 <<< (CW - 1)) - 64'sd1);
	localparam sw_t COORD_MIN = (W + 1)'(-(64'sd1 <<< (CW - 1)));

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
		uw_t     a;
		uw_t     b;
	} alu_cmd_t;

	typedef struct packed {
		logic done;
		uw_t  result;
	} alu_rsp_t;

	// clamp to the coordinate range
	function automatic coord_t sat(sw_t v);
		if (v > COORD_MAX) return COORD_MAX[CW-1:0];
		if (v < COORD_MIN) return COORD_MIN[CW-1:0];
		return v[CW-1:0];
	endfunction

	// magnitude of a signed value
	function automatic uw_t mag(sw_t v);
		sw_t t;
		t = v[W] ? -v : v;
		return t[W-1:0];
	endfunction

	// attach a sign to a magnitude
	function automatic sw_t signed_of(uw_t m, logic neg);
		sw_t t;
		t = {1'b0, m};
		return neg ? -t : t;
	endfunction

endpackage

// ===== hdl/psc_if.sv =====
// ----------------------------------------------------------------------------
// psc_if
// Valid/ready channels for vertices in and contour points out.
// ----------------------------------------------------------------------------
interface psc_vertex_if;
	import psc_pkg::*;

	logic   valid;
	logic   ready;
	coord_t pos_x;
	coord_t pos_y;
	logic   start_of_pass;
	logic   end_of_pass;

	modport source (output valid, pos_x, pos_y, start_of_pass, end_of_pass, input ready);
	modport sink (input valid, pos_x, pos_y, start_of_pass, end_of_pass, output ready);
endinterface

interface psc_contour_if;
	import psc_pkg::*;

	logic   valid;
	logic   ready;
	coord_t out_x;
	coord_t out_y;
	logic   last_of_run;

	modport source (output valid, out_x, out_y, last_of_run, input ready);
	modport sink (input valid, out_x, out_y, last_of_run, output ready);
endinterface

// ===== hdl/psc_alu.sv =====
// ----------------------------------------------------------------------------
// psc_alu
// Bit-serial unsigned multiply, restoring divide and integer square root.
// ----------------------------------------------------------------------------
module psc_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  psc_pkg::alu_cmd_t cmd,
	output psc_pkg::alu_rsp_t rsp
);
	import psc_pkg::*;

	logic             busy_q;
	alu_op_t          op_q;
	logic [W:0]       acc_q;
	uw_t              x_q;
	uw_t              y_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	uw_t              res_q;

	uw_t        acc_lo;
	uw_t        mul_nx;
	logic [W:0] rem2;
	logic       div_ge;
	logic [W:0] rem_nx;
	uw_t        quo_nx;
	uw_t        rb;
	logic       sq_ge;
	uw_t        v_nx;
	uw_t        r_nx;

	// one step of each operation
	always_comb begin
		acc_lo = acc_q[W-1:0];
		mul_nx = y_q[0] ? acc_lo + x_q : acc_lo;
		rem2   = {acc_q[W-1:0], x_q[W-1]};
		div_ge = rem2 >= {1'b0, y_q};
		rem_nx = div_ge ? rem2 - {1'b0, y_q} : rem2;
		quo_nx = {x_q[W-2:0], div_ge};
		rb     = x_q + y_q;
		sq_ge  = acc_lo >= rb;
		v_nx   = sq_ge ? acc_lo - rb : acc_lo;
		r_nx   = sq_ge ? (x_q >> 1) + y_q : x_q >> 1;
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			op_q   <= ALU_MUL;
			acc_q  <= '0;
			x_q    <= '0;
			y_q    <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
			res_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (cmd.start) begin
					busy_q <= 1'b1;
					op_q   <= cmd.op;
					unique case (cmd.op)
						ALU_MUL: begin
							acc_q <= '0;
							x_q   <= cmd.a;
							y_q   <= cmd.b;
						end
						ALU_DIV: begin
							acc_q <= '0;
							x_q   <= cmd.a;
							y_q   <= cmd.b;
							cnt_q <= CNT_W'(W);
						end
						ALU_SQRT: begin
							acc_q <= {1'b0, cmd.a};
							x_q   <= '0;
							y_q   <= uw_t'(1) << SQRT_TOP;
						end
						default: busy_q <= 1'b0;
					endcase
				end
			end else begin
				unique case (op_q)
					ALU_MUL: begin
						if (y_q == '0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
							res_q  <= acc_lo;
						end else begin
							acc_q <= {1'b0, mul_nx};
							x_q   <= x_q << 1;
							y_q   <= y_q >> 1;
						end
					end
					ALU_DIV: begin
						acc_q <= rem_nx;
						x_q   <= quo_nx;
						cnt_q <= cnt_q - CNT_W'(1);
						if (cnt_q == CNT_W'(1)) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
							res_q  <= quo_nx;
						end
					end
					ALU_SQRT: begin
						acc_q <= {1'b0, v_nx};
						x_q   <= r_nx;
						y_q   <= y_q >> 2;
						if (y_q == uw_t'(1)) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
							res_q  <= r_nx;
						end
					end
					default: busy_q <= 1'b0;
				endcase
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

// ===== hdl/polyline_stroke_contour_unit.sv =====
// ----------------------------------------------------------------------------
// polyline_stroke_contour_unit
// Takes polyline vertices one at a time and emits the right-hand side of a
// stroke outline offset by the half width, with miter points on left turns.
// Each vertex runs through a sequencer that drives one bit-serial unit for
// every multiply, square root and divide; a multiply stops early once no
// significant multiplier bits are left. Skipped segments need the fewest
// steps and left turns with a miter the most. The unit is the only multiply,
// divide and square-root resource, so its steps set the vertex time. Input
// is not ready while a vertex is at work; a finished contour point waits in
// an output register while the next vertex is taken. Coordinates are signed
// with 8 fraction bits.
// ----------------------------------------------------------------------------
module polyline_stroke_contour_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  psc_pkg::hw_t      cfg_wdata,
	psc_vertex_if.sink        vertex,
	psc_contour_if.source     contour
);
	import psc_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE, S_START, S_SQX, S_SQY, S_CHK, S_LEN, S_OXM, S_OXD, S_OYM, S_OYD,
		S_CR1, S_CR2, S_TURN, S_EMQ, S_M2, S_DN1, S_DN2, S_DCK, S_MS1, S_MS2,
		S_MSQ, S_LH1, S_LH2, S_RH, S_MR, S_MXM, S_MXD, S_MYM, S_MYD, S_EMM,
		S_UPD, S_END, S_EMIT
	} state_t;

	state_t   state_q;
	state_t   eret_q;
	logic     issued_q;
	hw_t      half_width_q;
	coord_t   bx_q, by_q;
	logic     st_q, en_q;
	coord_t   prev_x_q, prev_y_q;
	dw_t      last_dx_q, last_dy_q;
	lw_t      last_len_q;
	coord_t   pend_x_q, pend_y_q;
	logic     pend_v_q;
	dw_t      dx_q, dy_q;
	lw_t      len_q;
	uw_t      t_q, lhs_q;
	sw_t      ox_q, oy_q, cr_q, m2x_q, m2y_q, mx_q, my_q;
	coord_t   ex_q, ey_q;
	logic     elast_q;
	logic     out_valid_q;
	coord_t   out_x_q, out_y_q;
	logic     out_last_q;

	alu_cmd_t alu_cmd;
	alu_rsp_t alu_rsp;
	logic     is_op;
	logic     op_done;
	uw_t      res;
	uw_t      rr;
	uw_t      den_u;
	lw_t      lmax;
	sw_t      qx, qy;

	psc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (alu_cmd),
		.rsp    (alu_rsp)
	);

	// shared values for the sequencer
	always_comb begin
		res     = alu_rsp.result;
		rr      = uw_t'(half_width_q);
		den_u   = cr_q[W-1:0];
		lmax    = (len_q > last_len_q) ? len_q : last_len_q;
		qx      = sw_t'(prev_x_q) + ox_q;
		qy      = sw_t'(prev_y_q) + oy_q;
		op_done = issued_q && alu_rsp.done;
	end

	// operation issued in each compute step
	always_comb begin
		is_op       = 1'b1;
		alu_cmd.op  = ALU_MUL;
		alu_cmd.a   = '0;
		alu_cmd.b   = '0;
		unique case (state_q)
			S_SQX: begin alu_cmd.a = mag(sw_t'(dx_q)); alu_cmd.b = mag(sw_t'(dx_q)); end
			S_SQY: begin alu_cmd.a = mag(sw_t'(dy_q)); alu_cmd.b = mag(sw_t'(dy_q)); end
			S_LEN: begin alu_cmd.op = ALU_SQRT; alu_cmd.a = t_q; end
			S_OXM: begin alu_cmd.a = mag(sw_t'(dy_q)); alu_cmd.b = rr; end
			S_OYM: begin alu_cmd.a = mag(sw_t'(dx_q)); alu_cmd.b = rr; end
			S_OXD, S_OYD: begin
				alu_cmd.op = ALU_DIV;
				alu_cmd.a  = t_q + uw_t'(len_q >> 1);
				alu_cmd.b  = uw_t'(len_q);
			end
			S_CR1: begin alu_cmd.a = mag(sw_t'(last_dx_q)); alu_cmd.b = mag(sw_t'(dy_q)); end
			S_CR2: begin alu_cmd.a = mag(sw_t'(last_dy_q)); alu_cmd.b = mag(sw_t'(dx_q)); end
			S_DN1: begin alu_cmd.a = mag(sw_t'(dy_q)); alu_cmd.b = mag(m2x_q); end
			S_DN2: begin alu_cmd.a = mag(sw_t'(dx_q)); alu_cmd.b = mag(m2y_q); end
			S_MS1: begin alu_cmd.a = mag(m2x_q); alu_cmd.b = mag(m2x_q); end
			S_MS2: begin alu_cmd.a = mag(m2y_q); alu_cmd.b = mag(m2y_q); end
			S_MSQ: begin alu_cmd.op = ALU_SQRT; alu_cmd.a = t_q; end
			S_LH1: begin alu_cmd.a = t_q; alu_cmd.b = rr; end
			S_LH2: begin alu_cmd.a = t_q; alu_cmd.b = uw_t'(len_q); end
			S_RH: begin
				alu_cmd.a = uw_t'(lmax) + uw_t'(EPS_FIX + 1);
				alu_cmd.b = den_u;
			end
			S_MR: begin alu_cmd.a = uw_t'(len_q); alu_cmd.b = rr; end
			S_MXM: begin alu_cmd.a = mag(m2x_q); alu_cmd.b = t_q; end
			S_MYM: begin alu_cmd.a = mag(m2y_q); alu_cmd.b = t_q; end
			S_MXD, S_MYD: begin
				alu_cmd.op = ALU_DIV;
				alu_cmd.a  = lhs_q + (den_u >> 1);
				alu_cmd.b  = den_u;
			end
			default: is_op = 1'b0;
		endcase
		alu_cmd.start = is_op && !issued_q;
	end

	// sequencer, stroke state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			eret_q       <= S_IDLE;
			issued_q     <= 1'b0;
			half_width_q <= HW_RESET;
			bx_q         <= '0;
			by_q         <= '0;
			st_q         <= 1'b0;
			en_q         <= 1'b0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			last_dx_q    <= '0;
			last_dy_q    <= '0;
			last_len_q   <= '0;
			pend_x_q     <= '0;
			pend_y_q     <= '0;
			pend_v_q     <= 1'b0;
			dx_q         <= '0;
			dy_q         <= '0;
			len_q        <= '0;
			t_q          <= '0;
			lhs_q        <= '0;
			ox_q         <= '0;
			oy_q         <= '0;
			cr_q         <= '0;
			m2x_q        <= '0;
			m2y_q        <= '0;
			mx_q         <= '0;
			my_q         <= '0;
			ex_q         <= '0;
			ey_q         <= '0;
			elast_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_x_q      <= '0;
			out_y_q      <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (cfg_we) half_width_q <= cfg_wdata;

			// output register drains on transfer
			if (contour.ready && state_q != S_EMIT) out_valid_q <= 1'b0;

			// unit handshake
			if (is_op) begin
				if (!issued_q) issued_q <= 1'b1;
				else if (alu_rsp.done) issued_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (vertex.valid) begin
						bx_q <= vertex.pos_x;
						by_q <= vertex.pos_y;
						st_q <= vertex.start_of_pass;
						en_q <= vertex.end_of_pass;
						dx_q <= dw_t'(vertex.pos_x) - dw_t'(prev_x_q);
						dy_q <= dw_t'(vertex.pos_y) - dw_t'(prev_y_q);
						state_q <= vertex.start_of_pass ? S_START : S_SQX;
					end
				end
				// start of pass: flush held point and forget the last segment
				S_START: begin
					last_dx_q  <= '0;
					last_dy_q  <= '0;
					last_len_q <= '0;
					prev_x_q   <= bx_q;
					prev_y_q   <= by_q;
					pend_v_q   <= 1'b0;
					if (pend_v_q) begin
						ex_q    <= pend_x_q;
						ey_q    <= pend_y_q;
						elast_q <= 1'b1;
						eret_q  <= S_IDLE;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SQX: if (op_done) begin t_q <= res; state_q <= S_SQY; end
				S_SQY: if (op_done) begin t_q <= t_q + res; state_q <= S_CHK; end
				// segments shorter than one unit are skipped
				S_CHK: begin
					if (t_q < SQ_MIN) begin
						prev_x_q <= bx_q;
						prev_y_q <= by_q;
						state_q  <= S_END;
					end else begin
						state_q <= S_LEN;
					end
				end
				S_LEN: if (op_done) begin len_q <= res[CW:0]; state_q <= S_OXM; end
				S_OXM: if (op_done) begin t_q <= res; state_q <= S_OXD; end
				S_OXD: if (op_done) begin
					ox_q    <= signed_of(res, dy_q[CW]);
					state_q <= S_OYM;
				end
				S_OYM: if (op_done) begin t_q <= res; state_q <= S_OYD; end
				S_OYD: if (op_done) begin
					oy_q    <= signed_of(res, !dx_q[CW] && (dx_q != '0));
					state_q <= S_CR1;
				end
				S_CR1: if (op_done) begin
					cr_q    <= signed_of(res, last_dx_q[CW] ^ dy_q[CW]);
					state_q <= S_CR2;
				end
				S_CR2: if (op_done) begin
					cr_q    <= cr_q - signed_of(res, last_dy_q[CW] ^ dx_q[CW]);
					state_q <= S_TURN;
				end
				// right turn or straight: held point then plain offset point
				S_TURN: begin
					if (!cr_q[W] || !pend_v_q) begin
						if (pend_v_q) begin
							ex_q    <= pend_x_q;
							ey_q    <= pend_y_q;
							elast_q <= 1'b0;
							eret_q  <= S_EMQ;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_EMQ;
						end
					end else begin
						mx_q    <= (sw_t'(pend_x_q) + qx + sw_t'(1)) >>> 1;
						my_q    <= (sw_t'(pend_y_q) + qy + sw_t'(1)) >>> 1;
						m2x_q   <= sw_t'(pend_x_q) - sw_t'(prev_x_q) + ox_q;
						m2y_q   <= sw_t'(pend_y_q) - sw_t'(prev_y_q) + oy_q;
						state_q <= S_M2;
					end
				end
				S_EMQ: begin
					ex_q    <= sat(qx);
					ey_q    <= sat(qy);
					elast_q <= !en_q;
					eret_q  <= S_UPD;
					state_q <= S_EMIT;
				end
				// left turn: try the miter point
				S_M2: begin
					if ((m2x_q != '0 || m2y_q != '0) && half_width_q != '0) state_q <= S_DN1;
					else state_q <= S_EMM;
				end
				S_DN1: if (op_done) begin
					cr_q    <= signed_of(res, dy_q[CW] ^ m2x_q[W]);
					state_q <= S_DN2;
				end
				S_DN2: if (op_done) begin
					cr_q    <= cr_q - signed_of(res, dx_q[CW] ^ m2y_q[W]);
					state_q <= S_DCK;
				end
				S_DCK: state_q <= (!cr_q[W] && cr_q != '0) ? S_MS1 : S_EMM;
				S_MS1: if (op_done) begin t_q <= res; state_q <= S_MS2; end
				S_MS2: if (op_done) begin t_q <= t_q + res; state_q <= S_MSQ; end
				S_MSQ: if (op_done) begin t_q <= res; state_q <= S_LH1; end
				S_LH1: if (op_done) begin t_q <= res; state_q <= S_LH2; end
				S_LH2: if (op_done) begin lhs_q <= res; state_q <= S_RH; end
				// projected length within bounds, checked without a divide
				S_RH: if (op_done) begin
					state_q <= (lhs_q >= den_u && lhs_q < res) ? S_MR : S_EMM;
				end
				S_MR: if (op_done) begin t_q <= res; state_q <= S_MXM; end
				S_MXM: if (op_done) begin lhs_q <= res; state_q <= S_MXD; end
				S_MXD: if (op_done) begin
					mx_q    <= sw_t'(prev_x_q) + signed_of(res, m2x_q[W]);
					state_q <= S_MYM;
				end
				S_MYM: if (op_done) begin lhs_q <= res; state_q <= S_MYD; end
				S_MYD: if (op_done) begin
					my_q    <= sw_t'(prev_y_q) + signed_of(res, m2y_q[W]);
					state_q <= S_EMM;
				end
				S_EMM: begin
					ex_q    <= sat(mx_q);
					ey_q    <= sat(my_q);
					elast_q <= !en_q;
					eret_q  <= S_UPD;
					state_q <= S_EMIT;
				end
				// hold the new end point and keep this segment
				S_UPD: begin
					pend_x_q   <= sat(sw_t'(bx_q) + ox_q);
					pend_y_q   <= sat(sw_t'(by_q) + oy_q);
					pend_v_q   <= 1'b1;
					last_dx_q  <= dx_q;
					last_dy_q  <= dy_q;
					last_len_q <= len_q;
					prev_x_q   <= bx_q;
					prev_y_q   <= by_q;
					state_q    <= S_END;
				end
				// end of pass flushes the held point
				S_END: begin
					if (en_q && pend_v_q) begin
						pend_v_q <= 1'b0;
						ex_q     <= pend_x_q;
						ey_q     <= pend_y_q;
						elast_q  <= 1'b1;
						eret_q   <= S_IDLE;
						state_q  <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				// load the output register once it is free
				S_EMIT: begin
					if (!out_valid_q || contour.ready) begin
						out_valid_q <= 1'b1;
						out_x_q     <= ex_q;
						out_y_q     <= ey_q;
						out_last_q  <= elast_q;
						state_q     <= eret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign vertex.ready        = (state_q == S_IDLE);
	assign contour.valid       = out_valid_q;
	assign contour.out_x       = out_x_q;
	assign contour.out_y       = out_y_q;
	assign contour.last_of_run = out_last_q;

endmodule

// ===== hdl/psc_checker.sv =====
// ----------------------------------------------------------------------------
// psc_checker
// Port-level checks of the stroke contour unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psc_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input psc_pkg::coord_t out_x,
	input psc_pkg::coord_t out_y,
	input logic            out_last
);
	import psc_pkg::*;

	// a vertex transfer always starts work, so input drops the next cycle
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// a new contour point is only loaded while a vertex is at work
	`ASSERT_IMPLY(a_load_while_busy, clk, arst_n, $rose(out_valid), $past(!in_ready))

	// stalled result keeps valid
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// stalled result keeps its payload
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_x) && $stable(out_y) && $stable(out_last))

endmodule

bind polyline_stroke_contour_unit psc_checker u_psc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (vertex.valid),
	.in_ready  (vertex.ready),
	.out_valid (contour.valid),
	.out_ready (contour.ready),
	.out_x     (contour.out_x),
	.out_y     (contour.out_y),
	.out_last  (contour.last_of_run)
);

// ===== verif/polyline_stroke_contour_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_stroke_contour_unit_test
// Drives vertex passes with random gaps, stalls the contour side at random,
// and compares every contour point against a cycle-free predictor of the
// stroke offset, miter and flush rules. Half width is swept between phases.
// ----------------------------------------------------------------------------
module polyline_stroke_contour_unit_test;
	import psc_pkg::*;

	localparam int LIMIT = 4000000;
	localparam int DRAIN = 2000;

	typedef struct {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic last;
	} point_t;

	typedef struct {
		int x;
		int y;
		bit sp;
		bit ep;
		bit has_exp;
		int ex;
		int ey;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	hw_t cfg_wdata;
	psc_vertex_if vertex ();
	psc_contour_if contour ();

	polyline_stroke_contour_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.vertex(vertex),
		.contour(contour)
	);

	// predictor state
	longint unsigned r_half;
	longint p_x, p_y, seg_dx, seg_dy, seg_len, hold_x, hold_y;
	bit hold_v;
	point_t contour_queue[$];
	int errors;
	longint cycles;
	bit fixed_row;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	initial cycles = 0;

	// watchdog
	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("polyline_stroke_contour_unit regression: fail");
			$finish;
		end
	end

	task automatic report(input string what);
		errors++;
		$display("mismatch at cycle %0d: %s", cycles, what);
	endtask

	function automatic longint clamp(longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// floor or rounded a*b/c with a wide product, saturating
	function automatic longint unsigned scale_div(longint unsigned a, longint unsigned b,
			longint unsigned c, bit rnd);
		logic [127:0] p, q;
		p = 128'(a) * 128'(b);
		if (rnd) p += 128'(c >> 1);
		if ((p >> 64) >= 128'(c)) return 64'hFFFF_FFFF_FFFF_FFFF;
		q = p / 128'(c);
		return q[63:0];
	endfunction

	function automatic longint round_scale(longint a, longint unsigned b, longint unsigned c);
		longint unsigned m, q;
		m = a < 0 ? longint'(-a) : a;
		q = scale_div(m, b, c, 1'b1);
		if (q > (64'd1 << 62)) q = 64'd1 << 62;
		return a < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint mid_round(longint s);
		longint h;
		h = s + 1;
		return h >= 0 ? h / 2 : -((1 - h) / 2);
	endfunction

	function automatic void push_point(longint x, longint y);
		point_t e;
		e.x = 24'(clamp(x));
		e.y = 24'(clamp(y));
		e.last = 1'b0;
		contour_queue.push_back(e);
	endfunction

	// expected contour points of one vertex
	function automatic void predict_vertex(longint bx, longint by, bit sp, bit ep);
		longint dx, dy, ox, oy, crs, qx, qy, mx, my, m2x, m2y, den;
		longint unsigned sq, len, msq, mlen, proj, lmax;
		int n0;
		n0 = contour_queue.size();
		if (sp) begin
			if (hold_v) push_point(hold_x, hold_y);
			hold_v = 0;
			seg_dx = 0;
			seg_dy = 0;
			seg_len = 0;
		end else begin
			dx = bx - p_x;
			dy = by - p_y;
			sq = dx * dx + dy * dy;
			if (sq >= 65536) begin
				len = int_sqrt(sq);
				ox = round_scale(dy, r_half, len);
				oy = round_scale(-dx, r_half, len);
				crs = seg_dx * dy - seg_dy * dx;
				qx = p_x + ox;
				qy = p_y + oy;
				if (crs >= 0 || !hold_v) begin
					if (hold_v) push_point(hold_x, hold_y);
					push_point(qx, qy);
				end else begin
					mx = mid_round(hold_x + qx);
					my = mid_round(hold_y + qy);
					m2x = hold_x - p_x + ox;
					m2y = hold_y - p_y + oy;
					if ((m2x != 0 || m2y != 0) && r_half != 0) begin
						den = dy * m2x - dx * m2y;
						if (den > 0) begin
							msq = m2x * m2x + m2y * m2y;
							mlen = int_sqrt(msq);
							proj = scale_div(r_half * mlen, len, den, 1'b0);
							lmax = len > seg_len ? len : seg_len;
							if (proj > 0 && proj <= lmax + EPS_FIX) begin
								mx = p_x + round_scale(m2x, r_half * len, den);
								my = p_y + round_scale(m2y, r_half * len, den);
							end
						end
					end
					push_point(mx, my);
				end
				hold_x = clamp(bx + ox);
				hold_y = clamp(by + oy);
				hold_v = 1;
				seg_dx = dx;
				seg_dy = dy;
				seg_len = len;
			end
		end
		p_x = bx;
		p_y = by;
		if (ep && hold_v) begin
			push_point(hold_x, hold_y);
			hold_v = 0;
		end
		if (contour_queue.size() > n0) contour_queue[$].last = 1'b1;
	endfunction

	// random gap, mostly short
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	// contour side: random stalls and checking
	always @(posedge clk or negedge arst_n) begin
		point_t e;
		if (!arst_n) begin
			contour.ready <= 1'b0;
		end else begin
			if (contour.valid && contour.ready) begin
				if (contour_queue.size() == 0) begin
					report($sformatf("unexpected point (%0d,%0d)", contour.out_x,
						contour.out_y));
				end else begin
					e = contour_queue.pop_front();
					if (contour.out_x !== e.x)
						report($sformatf("out_x %0d, want %0d", contour.out_x, e.x));
					if (contour.out_y !== e.y)
						report($sformatf("out_y %0d, want %0d", contour.out_y, e.y));
					if (contour.last_of_run !== e.last)
						report($sformatf("last_of_run %0b, want %0b",
							contour.last_of_run, e.last));
				end
			end
			contour.ready <= ($urandom_range(0, 99) < 70) ||
				(cycles % 4000 < 600);
		end
	end

	// valid stays up across back-to-back transfers, drops only for a gap
	task automatic send_vertex(input int x, input int y, input bit sp, input bit ep);
		int g;
		g = gap_len();
		if (g > 0) begin
			vertex.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		vertex.valid <= 1'b1;
		vertex.pos_x <= coord_t'(x);
		vertex.pos_y <= coord_t'(y);
		vertex.start_of_pass <= sp;
		vertex.end_of_pass <= ep;
		@(posedge clk);
		while (!vertex.ready) @(posedge clk);
		predict_vertex(longint'(x), longint'(y), sp, ep);
	endtask

	task automatic settle();
		vertex.valid <= 1'b0;
		while (contour_queue.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_half(input hw_t v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		r_half = 64'(v);
	endtask

	function automatic int rnd_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return $urandom_range(0, 1) ? 8388607 : -8388608;
		if (r < 3) return int'($urandom) >>> 8;
		return int'($urandom_range(0, 40000)) - 20000;
	endfunction

	// directed rows
	row_t plan[$];
	function automatic void add_row(int x, int y, bit sp, bit ep, bit he = 0,
			int ex = 0, int ey = 0);
		row_t r;
		r.x = x;
		r.y = y;
		r.sp = sp;
		r.ep = ep;
		r.has_exp = he;
		r.ex = ex;
		r.ey = ey;
		plan.push_back(r);
	endfunction

	initial begin
		int x, y, n, k, m;
		point_t e;
		errors = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		vertex.valid = 1'b0;
		vertex.pos_x = '0;
		vertex.pos_y = '0;
		vertex.start_of_pass = 1'b0;
		vertex.end_of_pass = 1'b0;
		r_half = 256;
		p_x = 0; p_y = 0; seg_dx = 0; seg_dy = 0; seg_len = 0;
		hold_x = 0; hold_y = 0; hold_v = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// missing start: pairs with origin, R=1, offset (0,-256) then flush
		add_row(2560, 0, 0, 1, 1, 0, -256);
		add_row(0, 0, 1, 0);
		add_row(1000, 0, 0, 0);
		add_row(1000, 1000, 0, 0);    // right turn
		add_row(2000, 1000, 0, 0);    // left turn, miter
		add_row(2000, 1100, 0, 0);    // right turn
		add_row(2010, 1100, 0, 0);    // short segment, skipped
		add_row(1000, 1100, 0, 0);    // reversal
		add_row(1000, 1100, 0, 1);    // zero length with flush
		add_row(0, 0, 1, 0);
		add_row(8388607, 8388607, 0, 0);
		add_row(-8388608, -8388608, 0, 0);
		add_row(8388607, -8388608, 0, 0);
		add_row(-8388608, 8388607, 1, 1); // start with pending held
		add_row(0, 0, 0, 0);
		add_row(256, 0, 0, 0);
		add_row(256, 256, 0, 0);
		add_row(0, 256, 0, 1);
		for (int i = 0; i < plan.size(); i++) begin
			fixed_row = plan[i].has_exp;
			send_vertex(plan[i].x, plan[i].y, plan[i].sp, plan[i].ep);
			// typed-in check against prediction head for the first row
			if (fixed_row && contour_queue.size() > 0) begin
				e = contour_queue[0];
				if (e.x != plan[i].ex || e.y != plan[i].ey)
					report("predictor disagrees with directed row");
			end
		end
		settle();

		// phases over half width settings, extremes among them
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_half('0);
				1: write_half(20'hFFFFF);
				2: write_half(hw_t'($urandom_range(1, 2048)));
				3: write_half(hw_t'($urandom_range(1, 1048575)));
				default: write_half(hw_t'($urandom_range(64, 1024)));
			endcase
			n = 0;
			while (n < 30) begin
				// mostly well-formed passes, some noise
				m = $urandom_range(2, 6);
				x = rnd_coord();
				y = rnd_coord();
				send_vertex(x, y, $urandom_range(0, 9) != 0, 0);
				n++;
				for (k = 0; k < m; k++) begin
					x = int'(clamp(x + int'($urandom_range(0, 8000)) - 4000));
					y = int'(clamp(y + int'($urandom_range(0, 8000)) - 4000));
					if ($urandom_range(0, 12) == 0) begin
						x = rnd_coord();
						y = rnd_coord();
					end
					send_vertex(x, y, $urandom_range(0, 25) == 0,
						k == m - 1 || $urandom_range(0, 15) == 0);
					n++;
				end
			end
			settle();
		end

		if (errors == 0) begin
			$display("polyline_stroke_contour_unit regression: pass");
		end else begin
			$display("polyline_stroke_contour_unit regression: fail");
		end
		$finish;
	end

endmodule
